// ===== rtl/dltq_pkg.sv =====
package dltq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam logic [31:0] IDLE_WAIT_RST = 32'd1000;

    localparam logic REQ_ADVANCE = 1'b0;
    localparam logic REQ_ADD = 1'b1;

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] elapsed_ms;
        logic [7:0]  sleeper_id;
        logic [31:0] delay_ms;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  released_id;
        logic [31:0] next_wait;
        logic        full_error;
        logic        last;
    } t_out;

endpackage

// ===== rtl/delta_list_timer_queue.sv =====
// Channel     Direction  Handshake              Payload
// request     in         i_valid / o_ready      i_data  (dltq_pkg::t_in)
// result      out        o_valid / i_ready      o_data  (dltq_pkg::t_out)
// config      in         i_cfg_we               i_cfg_data (idle_wait)
//
// An item releases R entries, writes back the reduced head delta (B, 0 or 1), walks
// W nodes to find the insert point and makes L (0 to 2) link writes. R + W never
// exceeds DEPTH, and the node memory serves one read a cycle. Reset is synchronous,
// active low; the memories need no clearing pass. A result beat that is not taken
// stalls the release and summary steps until i_ready is high.
module delta_list_timer_queue #(
    parameter int DEPTH = dltq_pkg::DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dltq_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output dltq_pkg::t_out o_data,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_data
);

    // Index width of a list node, and width of counters that can hold DEPTH.
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // A node holds its delta, its sleeper id and the index of the next node.
    localparam int NW = 32 + 8 + IW;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_REL   = 8'b0000_0010,
        S_INS   = 8'b0000_0100,
        S_WALK  = 8'b0000_1000,
        S_LINK  = 8'b0001_0000,
        S_LINK2 = 8'b0010_0000,
        S_SUM   = 8'b0100_0000,
        S_SUM2  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // The queue is a singly linked list kept in the node memory. Nodes that
    // were released go onto a free stack in a second memory; nodes never used
    // yet are handed out by an allocation count, so nothing needs clearing.
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_head, n_head;
    logic [CW-1:0] r_alloc, n_alloc;
    logic [CW-1:0] r_sp, n_sp;

    // The item under work.
    logic          r_req, n_req;
    logic [31:0]   r_elapsed, n_elapsed;
    logic [7:0]    r_sid, n_sid;
    logic [31:0]   r_delay, n_delay;
    logic          r_err, n_err;

    // Walk state for the insertion.
    logic [IW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_left, n_left;
    logic          r_has_prev, n_has_prev;
    logic [NW-1:0] r_pnode, n_pnode;
    logic [IW-1:0] r_pidx, n_pidx;
    logic [IW-1:0] r_nxt, n_nxt;
    logic          r_pop, n_pop;
    logic [IW-1:0] r_idx, n_idx;

    logic [31:0]   r_idle;

    logic           r_ov, n_ov;
    dltq_pkg::t_out r_out, n_out;

    // Memory ports.
    logic          nd_we, nd_re;
    logic [IW-1:0] nd_waddr, nd_raddr;
    logic [NW-1:0] nd_wdata, nd_rdata;
    logic          fs_we, fs_re;
    logic [IW-1:0] fs_waddr, fs_raddr;
    logic [IW-1:0] fs_wdata, fs_rdata;

    logic [31:0]   rd_delta;
    logic [7:0]    rd_id;
    logic [IW-1:0] rd_next;
    logic          out_free;
    logic [IW-1:0] new_idx;

    dltq_ram #(.W(NW), .D(DEPTH)) u_nodes (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wdata),
        .i_re    (nd_re),
        .i_raddr (nd_raddr),
        .o_rdata (nd_rdata)
    );

    dltq_ram #(.W(IW), .D(DEPTH)) u_free (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_re    (fs_re),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    assign rd_delta = nd_rdata[NW-1 -: 32];
    assign rd_id    = nd_rdata[IW +: 8];
    assign rd_next  = nd_rdata[IW-1:0];

    // The output register may be refilled in the cycle its beat is taken.
    assign out_free = !r_ov || i_ready;
    assign new_idx  = r_pop ? fs_rdata : r_alloc[IW-1:0];

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_head     = r_head;
        n_alloc    = r_alloc;
        n_sp       = r_sp;
        n_req      = r_req;
        n_elapsed  = r_elapsed;
        n_sid      = r_sid;
        n_delay    = r_delay;
        n_err      = r_err;
        n_cur      = r_cur;
        n_left     = r_left;
        n_has_prev = r_has_prev;
        n_pnode    = r_pnode;
        n_pidx     = r_pidx;
        n_nxt      = r_nxt;
        n_pop      = r_pop;
        n_idx      = r_idx;
        n_ov       = r_ov;
        n_out      = r_out;
        nd_we      = 1'b0;
        nd_waddr   = r_head;
        nd_wdata   = nd_rdata;
        nd_re      = 1'b0;
        nd_raddr   = r_head;
        fs_we      = 1'b0;
        fs_waddr   = r_sp[IW-1:0];
        fs_wdata   = r_head;
        fs_re      = 1'b0;
        fs_raddr   = IW'(r_sp - ONE_C);

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req     = i_data.req_type;
                    n_elapsed = i_data.elapsed_ms;
                    n_sid     = i_data.sleeper_id;
                    n_delay   = i_data.delay_ms;
                    n_err     = 1'b0;
                    if (r_count != '0) begin
                        nd_re   = 1'b1;
                        n_state = S_REL;
                    end else begin
                        n_state = S_INS;
                    end
                end
            end
            S_REL: begin
                if (r_elapsed >= rd_delta) begin
                    if (out_free) begin
                        n_ov              = 1'b1;
                        n_out.kind        = dltq_pkg::KIND_RELEASE;
                        n_out.released_id = rd_id;
                        n_out.next_wait   = '0;
                        n_out.full_error  = 1'b0;
                        n_out.last        = 1'b0;
                        n_elapsed         = r_elapsed - rd_delta;
                        fs_we             = 1'b1;
                        n_sp              = r_sp + ONE_C;
                        n_head            = rd_next;
                        n_count           = r_count - ONE_C;
                        if (r_count > ONE_C) begin
                            nd_re    = 1'b1;
                            nd_raddr = rd_next;
                        end else begin
                            n_state = S_INS;
                        end
                    end
                end else begin
                    nd_we    = 1'b1;
                    nd_wdata = {rd_delta - r_elapsed, rd_id, rd_next};
                    n_state  = S_INS;
                end
            end
            S_INS: begin
                if (r_req != dltq_pkg::REQ_ADD) begin
                    n_state = S_SUM;
                end else if (r_count == DEPTH_C) begin
                    n_err   = 1'b1;
                    n_state = S_SUM;
                end else begin
                    n_pop      = (r_sp != '0);
                    fs_re      = (r_sp != '0);
                    n_has_prev = 1'b0;
                    n_cur      = r_head;
                    n_left     = r_count;
                    n_nxt      = '0;
                    if (r_count != '0) begin
                        nd_re   = 1'b1;
                        n_state = S_WALK;
                    end else begin
                        n_state = S_LINK;
                    end
                end
            end
            S_WALK: begin
                if (r_delay > rd_delta) begin
                    n_delay    = r_delay - rd_delta;
                    n_has_prev = 1'b1;
                    n_pnode    = nd_rdata;
                    n_pidx     = r_cur;
                    n_cur      = rd_next;
                    n_left     = r_left - ONE_C;
                    if (r_left > ONE_C) begin
                        nd_re    = 1'b1;
                        nd_raddr = rd_next;
                    end else begin
                        n_nxt   = '0;
                        n_state = S_LINK;
                    end
                end else begin
                    // The new sleeper goes ahead of this node.
                    nd_we    = 1'b1;
                    nd_waddr = r_cur;
                    nd_wdata = {rd_delta - r_delay, rd_id, rd_next};
                    n_nxt    = r_cur;
                    n_state  = S_LINK;
                end
            end
            S_LINK: begin
                nd_we    = 1'b1;
                nd_waddr = new_idx;
                nd_wdata = {r_delay, r_sid, r_nxt};
                n_idx    = new_idx;
                n_count  = r_count + ONE_C;
                if (r_pop) begin
                    n_sp = r_sp - ONE_C;
                end else begin
                    n_alloc = r_alloc + ONE_C;
                end
                if (r_has_prev) begin
                    n_state = S_LINK2;
                end else begin
                    n_head  = new_idx;
                    n_state = S_SUM;
                end
            end
            S_LINK2: begin
                nd_we    = 1'b1;
                nd_waddr = r_pidx;
                nd_wdata = {r_pnode[NW-1:IW], r_idx};
                n_state  = S_SUM;
            end
            S_SUM: begin
                if (r_count != '0) begin
                    nd_re   = 1'b1;
                    n_state = S_SUM2;
                end else if (out_free) begin
                    n_ov              = 1'b1;
                    n_out.kind        = dltq_pkg::KIND_SUMMARY;
                    n_out.released_id = '0;
                    n_out.next_wait   = r_idle;
                    n_out.full_error  = r_err;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_SUM2: begin
                if (out_free) begin
                    n_ov              = 1'b1;
                    n_out.kind        = dltq_pkg::KIND_SUMMARY;
                    n_out.released_id = '0;
                    n_out.next_wait   = rd_delta;
                    n_out.full_error  = r_err;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_alloc <= '0;
            r_sp    <= '0;
            r_ov    <= 1'b0;
            r_idle  <= dltq_pkg::IDLE_WAIT_RST;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_alloc <= n_alloc;
            r_sp    <= n_sp;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_idle <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head     <= n_head;
        r_req      <= n_req;
        r_elapsed  <= n_elapsed;
        r_sid      <= n_sid;
        r_delay    <= n_delay;
        r_err      <= n_err;
        r_cur      <= n_cur;
        r_left     <= n_left;
        r_has_prev <= n_has_prev;
        r_pnode    <= n_pnode;
        r_pidx     <= n_pidx;
        r_nxt      <= n_nxt;
        r_pop      <= n_pop;
        r_idx      <= n_idx;
        r_out      <= n_out;
    end

`ifndef NO_ASSERTIONS
    // The queue never holds more sleepers than it has nodes.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count above depth");

    // Between items every allocated node is either queued or on the free stack.
    a_node_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (CW'(r_sp + r_count) == r_alloc))
        else $error("node accounting lost a node");

    // Only a summary beat closes an item.
    a_last_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.last) |-> (r_out.kind == dltq_pkg::KIND_SUMMARY))
        else $error("last flag on a release beat");
`endif

endmodule

// ===== rtl/dltq_ram.sv =====
module dltq_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/delta_list_timer_queue_test.sv =====
`timescale 1ns / 1ps

module delta_list_timer_queue_test;

    localparam int QDEPTH = dltq_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 2 * QDEPTH + 20;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    dltq_pkg::t_in  i_data;
    logic           o_valid;
    logic           i_ready;
    dltq_pkg::t_out o_data;
    logic           i_cfg_we;
    logic [31:0]    i_cfg_data;

    delta_list_timer_queue #(.DEPTH(QDEPTH)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the timer list that the predictor keeps in step with the block.
    logic [31:0] shadow_delta [QDEPTH];
    logic [7:0]  shadow_id [QDEPTH];
    int          shadow_count;
    logic [31:0] shadow_idle_wait;

    // Expected result beats, oldest first.
    dltq_pkg::t_out pending_results [$];
    int          error_count;
    int          cycle_count;
    int          stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The run is cut off once the cycle count passes CYCLE_LIMIT, so a block that stops making progress cannot hang it.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Works out the result beats for one accepted request and updates the shadow list.
    task automatic predict_timer_step(input dltq_pkg::t_in req);
        logic [31:0] left;
        logic [31:0] dly;
        int          pos;
        logic        dropped;
        dltq_pkg::t_out beat;
        left = req.elapsed_ms;
        dropped = 1'b0;
        // Release phase: every head entry whose delta is covered expires.
        // A zero delta expires even when no time has passed.
        while (shadow_count > 0) begin
            if (left >= shadow_delta[0]) begin
                left -= shadow_delta[0];
                beat = '0;
                beat.kind = dltq_pkg::KIND_RELEASE;
                beat.released_id = shadow_id[0];
                pending_results.push_back(beat);
                for (int i = 0; i < shadow_count - 1; i++) begin
                    shadow_delta[i] = shadow_delta[i + 1];
                    shadow_id[i] = shadow_id[i + 1];
                end
                shadow_count--;
            end else begin
                shadow_delta[0] -= left;
                break;
            end
        end
        // Insert phase. Equal delays go ahead of the existing entry.
        if (req.req_type == dltq_pkg::REQ_ADD) begin
            if (shadow_count >= QDEPTH) begin
                dropped = 1'b1;
            end else begin
                dly = req.delay_ms;
                pos = 0;
                while (pos < shadow_count) begin
                    if (dly > shadow_delta[pos]) begin
                        dly -= shadow_delta[pos];
                        pos++;
                    end else begin
                        shadow_delta[pos] -= dly;
                        break;
                    end
                end
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_delta[i] = shadow_delta[i - 1];
                    shadow_id[i] = shadow_id[i - 1];
                end
                shadow_delta[pos] = dly;
                shadow_id[pos] = req.sleeper_id;
                shadow_count++;
            end
        end
        beat = '0;
        beat.kind = dltq_pkg::KIND_SUMMARY;
        beat.next_wait = (shadow_count != 0) ? shadow_delta[0] : shadow_idle_wait;
        beat.full_error = dropped;
        beat.last = 1'b1;
        pending_results.push_back(beat);
    endtask

    // Receiver: stalls follow a mode that the tests change, and every taken beat
    // is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat", o_data.next_wait, 32'd0);
                end else begin
                    dltq_pkg::t_out want;
                    want = pending_results.pop_front();
                    if (o_data.kind !== want.kind)
                        report_mismatch("kind", 32'(o_data.kind), 32'(want.kind));
                    if (o_data.released_id !== want.released_id)
                        report_mismatch("released_id", 32'(o_data.released_id),
                                        32'(want.released_id));
                    if (o_data.next_wait !== want.next_wait)
                        report_mismatch("next_wait", o_data.next_wait, want.next_wait);
                    if (o_data.full_error !== want.full_error)
                        report_mismatch("full_error", 32'(o_data.full_error),
                                        32'(want.full_error));
                    if (o_data.last !== want.last)
                        report_mismatch("last", 32'(o_data.last), 32'(want.last));
                end
            end
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 3) != 0);
                default: i_ready <= (cycle_count % 7 < 3);
            endcase
        end
    end

    // Sends one request beat and holds it until the block takes it. Valid is then dropped and
    // the task returns only after the next edge, so that valid is never driven twice in a step.
    task automatic send_request(input dltq_pkg::t_in req);
        i_valid <= 1'b1;
        i_data <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_timer_step(req);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_with_gaps(input dltq_pkg::t_in req);
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        send_request(req);
    endtask

    task automatic wait_until_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_idle_wait(input logic [31:0] value);
        wait_until_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_idle_wait = value;
    endtask

    function automatic dltq_pkg::t_in make_request(input logic kind,
                                                   input logic [31:0] elapsed,
                                                   input logic [7:0] sid,
                                                   input logic [31:0] dly);
        dltq_pkg::t_in r;
        r.req_type = kind;
        r.elapsed_ms = elapsed;
        r.sleeper_id = sid;
        r.delay_ms = dly;
        return r;
    endfunction

    // Directed: empty queue, extremes of every field, zero delay, equal delays,
    // and a queue filled to overflow.
    task automatic test_directed();
        stall_mode = 0;
        send_request(make_request(dltq_pkg::REQ_ADVANCE, 32'd0, 8'hFF, 32'hFFFF_FFFF));
        send_request(make_request(dltq_pkg::REQ_ADD, 32'd0, 8'h00, 32'd0));
        send_request(make_request(dltq_pkg::REQ_ADVANCE, 32'd0, 8'h00, 32'd0));
        send_request(make_request(dltq_pkg::REQ_ADD, 32'd5, 8'hFF, 32'hFFFF_FFFF));
        send_request(make_request(dltq_pkg::REQ_ADD, 32'd0, 8'h11, 32'd100));
        send_request(make_request(dltq_pkg::REQ_ADD, 32'd0, 8'h22, 32'd100));
        send_request(make_request(dltq_pkg::REQ_ADD, 32'd0, 8'h33, 32'd40));
        send_request(make_request(dltq_pkg::REQ_ADVANCE, 32'd100, 8'h00, 32'd0));
        send_request(make_request(dltq_pkg::REQ_ADVANCE, 32'hFFFF_FFFF, 8'h00, 32'd0));
        for (int i = 0; i < QDEPTH + 2; i++) begin
            send_request(make_request(dltq_pkg::REQ_ADD, 32'd0, 8'(i), 32'(i * 3)));
        end
        send_request(make_request(dltq_pkg::REQ_ADVANCE, 32'hFFFF_FFFF, 8'h00, 32'd0));
    endtask

    // Random traffic: mostly adds with small times so the list stays busy.
    task automatic test_random(input int count);
        dltq_pkg::t_in r;
        for (int n = 0; n < count; n++) begin
            if (n % 30 == 0) stall_mode = $urandom_range(0, 2);
            r.req_type = ($urandom_range(0, 9) < 7) ? dltq_pkg::REQ_ADD
                                                    : dltq_pkg::REQ_ADVANCE;
            r.sleeper_id = 8'($urandom);
            case ($urandom_range(0, 9))
                0: r.elapsed_ms = $urandom;
                1, 2, 3: r.elapsed_ms = 32'd0;
                default: r.elapsed_ms = $urandom_range(0, 60);
            endcase
            case ($urandom_range(0, 9))
                0: r.delay_ms = $urandom;
                1: r.delay_ms = 32'd0;
                default: r.delay_ms = $urandom_range(0, 200);
            endcase
            send_with_gaps(r);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        stall_mode = 0;
        shadow_count = 0;
        shadow_idle_wait = dltq_pkg::IDLE_WAIT_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_idle_wait(32'd0);
        send_request(make_request(dltq_pkg::REQ_ADVANCE, 32'd0, 8'h00, 32'd0));
        test_random(40);
        write_idle_wait(32'hFFFF_FFFF);
        send_request(make_request(dltq_pkg::REQ_ADVANCE, 32'hFFFF_FFFF, 8'h00, 32'd0));
        test_random(40);
        write_idle_wait($urandom);
        test_random(30);
        send_request(make_request(dltq_pkg::REQ_ADVANCE, 32'hFFFF_FFFF, 8'h00, 32'd0));
        wait_until_idle();

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dltq_pkg.sv
rtl/dltq_ram.sv
rtl/delta_list_timer_queue.sv
test/delta_list_timer_queue_test.sv
